// File: sv/stfid_pkg.sv
// Package for the sorted key/value table: widths, operation and status codes,
// sequencer state type and parameter defaults.
// No dependencies.
`default_nettype none

package stfid_pkg;

  // parameter defaults
  localparam int DEPTH_DEF   = 64;
  localparam int KEY_W_DEF   = 32;
  localparam int VALUE_W_DEF = 32;

  // fixed port widths
  localparam int OP_W     = 2;
  localparam int KEY_PW   = 32;
  localparam int VALUE_PW = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;
  localparam int CAP_W    = 7;
  localparam int EXT_W    = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_DUP    = 3'd2,
    STAT_EMPTY  = 3'd3,
    STAT_ABSENT = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_HIT_CMP,
    S_EVAL,
    S_UP_RD,
    S_UP_WR,
    S_WR_NEW,
    S_DN_RD,
    S_DN_WR,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: sv/sorted_table_find_insert_delete.sv
// Sequence: a find runs a binary search, each step reading and then comparing the midpoint
// key, then checks the slot found for a hit, decides and loads the result register; insert
// also moves each record above the slot up one and writes the new record, delete moves them down one.
// Throughput: one item at a time; in_ready is high only while the sequencer is idle.
// Reset: synchronous active low; clears count, sequencer and out_valid, capacity to 64;
// the record RAM is not cleared: only slots below the record count are ever read.
`default_nettype none

module sorted_table_find_insert_delete
  import stfid_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int KEY_W   = KEY_W_DEF,
  parameter int VALUE_W = VALUE_W_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [KEY_PW-1:0]   in_key,
  input  wire logic [VALUE_PW-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_found,
  output logic [POS_W-1:0]         out_position,
  output logic [POS_W-1:0]         out_record_count,
  // capacity register write
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CAP_W-1:0]    cfg_capacity
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = KEY_W + VALUE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  status_t              stat_r, stat_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  logic                 hit_r, hit_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]     out_cnt_r, out_cnt_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [KEY_W-1:0]     rd_key;

  logic [EXT_W-1:0]     key_ext;
  logic [EXT_W-1:0]     value_ext;
  logic [31:0]          cap_wide;
  logic [31:0]          lo_wide;
  logic [31:0]          used_wide;
  logic [CW-1:0]        cap_eff;
  logic [CW-1:0]        mid_calc;
  logic [CW-1:0]        lo_step;

  // record RAM: key in the upper bits, value in the lower bits
  stfid_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[DW-1:VALUE_W];

  // input fields reduced to the stored widths
  assign key_ext   = {{(EXT_W-KEY_PW){1'b0}}, in_key};
  assign value_ext = {{(EXT_W-VALUE_PW){1'b0}}, in_value};

  // effective capacity, limited to the table depth
  assign cap_wide = 32'(cap_r);
  assign cap_eff  = (cap_wide > 32'(DEPTH)) ? DEPTH_C : cap_wide[CW-1:0];

  // resized counters for the result fields
  assign lo_wide   = 32'(lo_r);
  assign used_wide = 32'(used_r);

  // binary search midpoint and next lower bound
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_step  = mid_r + 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity;
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      lo_r        <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      lo_r        <= lo_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    stat_r       <= stat_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    stat_nxt       = stat_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt   = key_ext[KEY_W-1:0];
          value_nxt = value_ext[VALUE_W-1:0];
          lo_nxt    = '0;
          hi_nxt    = used_r;
          hit_nxt   = 1'b0;
          case (in_op)
            OP_INSERT: op_nxt = OP_INSERT;
            OP_DELETE: op_nxt = OP_DELETE;
            default:   op_nxt = OP_FIND;
          endcase
          // refusals that need no search
          if (op_nxt == OP_INSERT && used_r >= cap_eff) begin
            stat_nxt  = STAT_FULL;
            state_nxt = S_FINISH;
          end else if (op_nxt == OP_DELETE && used_r == '0) begin
            stat_nxt  = STAT_EMPTY;
            state_nxt = S_FINISH;
          end else if (used_r == '0) begin
            state_nxt = S_EVAL;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end

      // issue the read of the midpoint key
      S_SRCH_RD: begin
        mid_nxt   = mid_calc;
        ram_raddr = mid_calc[AW-1:0];
        state_nxt = S_SRCH_CMP;
      end

      // narrow the range; when it closes, read the slot found if it holds a record
      S_SRCH_CMP: begin
        if (rd_key < key_r) begin
          lo_nxt = lo_step;
        end else begin
          hi_nxt = mid_r;
        end
        if (lo_nxt < hi_nxt) begin
          state_nxt = S_SRCH_RD;
        end else if (lo_nxt < used_r) begin
          ram_raddr = lo_nxt[AW-1:0];
          state_nxt = S_HIT_CMP;
        end else begin
          state_nxt = S_EVAL;
        end
      end

      S_HIT_CMP: begin
        hit_nxt   = (rd_key == key_r);
        state_nxt = S_EVAL;
      end

      // decide what the operation does with the search result
      S_EVAL: begin
        unique case (op_r)
          OP_INSERT: begin
            if (hit_r) begin
              stat_nxt  = STAT_DUP;
              state_nxt = S_FINISH;
            end else begin
              idx_nxt   = used_r;
              state_nxt = (used_r > lo_r) ? S_UP_RD : S_WR_NEW;
            end
          end
          OP_DELETE: begin
            if (!hit_r) begin
              stat_nxt  = STAT_ABSENT;
              state_nxt = S_FINISH;
            end else if (lo_r + 1'b1 < used_r) begin
              idx_nxt   = lo_r;
              state_nxt = S_DN_RD;
            end else begin
              used_nxt  = used_r - 1'b1;
              stat_nxt  = STAT_OK;
              state_nxt = S_FINISH;
            end
          end
          default: begin
            stat_nxt  = hit_r ? STAT_OK : STAT_ABSENT;
            state_nxt = S_FINISH;
          end
        endcase
      end

      // open a gap: move records up one slot, highest first
      S_UP_RD: begin
        ram_raddr = idx_r[AW-1:0] - 1'b1;
        state_nxt = S_UP_WR;
      end

      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = (idx_nxt > lo_r) ? S_UP_RD : S_WR_NEW;
      end

      S_WR_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r[AW-1:0];
        ram_wdata = {key_r, value_r};
        used_nxt  = used_r + 1'b1;
        stat_nxt  = STAT_OK;
        state_nxt = S_FINISH;
      end

      // close the gap: move records down one slot, lowest first
      S_DN_RD: begin
        ram_raddr = idx_r[AW-1:0] + 1'b1;
        state_nxt = S_DN_WR;
      end

      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r + 2'd2 < used_r) begin
          state_nxt = S_DN_RD;
        end else begin
          used_nxt  = used_r - 1'b1;
          stat_nxt  = STAT_OK;
          state_nxt = S_FINISH;
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          if (stat_r == STAT_FULL || stat_r == STAT_EMPTY) begin
            out_found_nxt = 1'b0;
            out_pos_nxt   = '0;
          end else begin
            out_found_nxt = hit_r;
            out_pos_nxt   = lo_wide[POS_W-1:0];
          end
          out_cnt_nxt = used_wide[POS_W-1:0];
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_position     = out_pos_r;
  assign out_record_count = out_cnt_r;

endmodule

`default_nettype wire

// File: sv/stfid_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stfid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/stfid_checker.sv
// Port-level checks for the sorted key/value table, bound to the top level.
// Depends on stfid_pkg and sorted_table_find_insert_delete.
`default_nettype none

module stfid_checker
  import stfid_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic                out_found,
  input wire logic [POS_W-1:0]    out_position,
  input wire logic [POS_W-1:0]    out_record_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_position) && $stable(out_record_count))
    else $error("result changed while stalled");

  // refusals without a search report no hit at slot zero
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL || out_status == STAT_EMPTY)
      |-> !out_found && out_position == '0)
    else $error("full or empty result with a slot or hit");

  // found flag agrees with a duplicate or absent status
  a_found_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_DUP || out_status == STAT_ABSENT)
      |-> out_found == (out_status == STAT_DUP))
    else $error("found flag disagrees with status");

  // a slot never lies beyond the records held
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= out_record_count)
    else $error("slot beyond record count");

endmodule

bind sorted_table_find_insert_delete stfid_checker u_stfid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_found        (out_found),
  .out_position     (out_position),
  .out_record_count (out_record_count)
);

`default_nettype wire

// File: bench/sorted_table_checker.sv
// Checker for the sorted key/value table: watches the request, result and capacity
// channels, predicts each result from its own copy of the table and compares.
// Depends on stfid_pkg for widths, operation and status codes.
`timescale 1ns / 100ps

module sorted_table_checker
  import stfid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KEY_PW-1:0]   in_key,
  input  logic [VALUE_PW-1:0] in_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic                out_found,
  input  logic [POS_W-1:0]    out_position,
  input  logic [POS_W-1:0]    out_record_count,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_capacity,
  output int                  fail_count,
  output int                  outstanding,
  output int                  results_checked
);

  typedef struct packed {
    status_t          status;
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] record_count;
  } table_result_t;

  // predicted table contents, kept in ascending key order
  logic [KEY_PW-1:0]   key_mem [DEPTH_DEF];
  logic [VALUE_PW-1:0] val_mem [DEPTH_DEF];
  int unsigned         rec_count;
  int unsigned         cap_reg;

  table_result_t expected_results [$];

  // first slot whose key is not below the searched key
  function automatic int unsigned first_slot_not_below(input logic [KEY_PW-1:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = rec_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_mem[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // apply one request to the predicted table and return its result
  function automatic table_result_t table_update(input logic [OP_W-1:0] op,
                                                 input logic [KEY_PW-1:0] key,
                                                 input logic [VALUE_PW-1:0] value);
    table_result_t res;
    int unsigned   limit, slot, i;
    logic          hit;
    limit = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : cap_reg;
    slot = 0;
    hit = 1'b0;
    res.status = STAT_OK;
    case (op)
      OP_INSERT: begin
        if (rec_count >= limit) begin
          res.status = STAT_FULL;
        end else begin
          slot = first_slot_not_below(key);
          hit = (slot < rec_count) && (key_mem[slot] == key);
          if (hit) begin
            res.status = STAT_DUP;
          end else begin
            // open a gap at the insertion slot
            for (i = rec_count; i > slot; i--) begin
              key_mem[i] = key_mem[i-1];
              val_mem[i] = val_mem[i-1];
            end
            key_mem[slot] = key;
            val_mem[slot] = value;
            rec_count++;
          end
        end
      end
      OP_DELETE: begin
        if (rec_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          slot = first_slot_not_below(key);
          hit = (slot < rec_count) && (key_mem[slot] == key);
          if (!hit) begin
            res.status = STAT_ABSENT;
          end else begin
            // close the gap left by the removed record
            for (i = slot; i + 1 < rec_count; i++) begin
              key_mem[i] = key_mem[i+1];
              val_mem[i] = val_mem[i+1];
            end
            rec_count--;
          end
        end
      end
      default: begin
        // find, and the spare op code behaves as find
        slot = first_slot_not_below(key);
        hit = (slot < rec_count) && (key_mem[slot] == key);
        res.status = hit ? STAT_OK : STAT_ABSENT;
      end
    endcase
    res.found = hit;
    res.position = slot[POS_W-1:0];
    res.record_count = rec_count[POS_W-1:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // channel monitor: capacity writes, result compare, then new requests
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      rec_count = 0;
      cap_reg = 32'(CAP_RESET);
      fail_count = 0;
      results_checked = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = 32'(cfg_capacity);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result item with none expected, status %0d position %0d",
                   $time, out_status, out_position);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("found", 32'(want.found), 32'(out_found));
          check_field("position", 32'(want.position), 32'(out_position));
          check_field("record_count", 32'(want.record_count), 32'(out_record_count));
          results_checked++;
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(table_update(in_op, in_key, in_value));
    end
    outstanding <= expected_results.size();
  end

endmodule

// File: bench/sorted_table_find_insert_delete_test.sv
// Testbench top for the sorted key/value table: clock, reset, request and capacity
// stimulus, result-side stalls and the verdict.
// Depends on stfid_pkg, sorted_table_find_insert_delete and sorted_table_checker.
`timescale 1ns / 100ps

module sorted_table_find_insert_delete_test
  import stfid_pkg::*;
();

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int POOL_SIZE      = 96;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 80;
  localparam int LONG_HOLD      = 400;
  localparam int LATENCY_SLACK  = 200;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_op;
  logic [KEY_PW-1:0]   in_key;
  logic [VALUE_PW-1:0] in_value;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [POS_W-1:0]    out_position;
  logic [POS_W-1:0]    out_record_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_capacity;

  int fail_count;
  int outstanding;
  int results_checked;

  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       hold_requests;
  int unsigned       item_count;
  int unsigned       cfg_writes;
  logic [KEY_PW-1:0] key_pool [POOL_SIZE];

  sorted_table_find_insert_delete DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_key           (in_key),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_record_count (out_record_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_capacity     (cfg_capacity)
  );

  sorted_table_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_key           (in_key),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_record_count (out_record_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_capacity     (cfg_capacity),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .results_checked  (results_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("run timed out at %0t ns", $time);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned seen_holds;
    seen_holds = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one item, with random gaps before it, and wait for acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_PW-1:0] key,
                              input logic [VALUE_PW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // mostly keys from a small pool so hits, duplicates and a full table are common
  task automatic send_random_request();
    int unsigned       r;
    logic [OP_W-1:0]   op;
    logic [KEY_PW-1:0] key;
    r = $urandom_range(99);
    if (r < 45) op = OP_INSERT;
    else if (r < 75) op = OP_DELETE;
    else if (r < 95) op = OP_FIND;
    else op = OP_SPARE;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else key = $urandom;
    send_request(op, key, $urandom);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned      phase, n;
    logic [CAP_W-1:0] phase_caps [PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_FIND;
    in_key = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_capacity = CAP_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    item_count = 0;
    cfg_writes = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (n = 4; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    phase_caps = '{7'd64, 7'd20, 7'd127, 7'd3, 7'd64, 7'd0, 7'd1, 7'd64};
    phase_caps[6] = CAP_W'($urandom_range(64, 1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, misses, spare op code
    write_capacity(7'd64);
    send_request(OP_FIND, '0, '0);
    send_request(OP_DELETE, '1, '1);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, 32'h8000_0000, '1);
    send_request(OP_INSERT, '0, '1);
    send_request(OP_FIND, '0, '0);
    send_request(OP_FIND, '1, '0);
    send_request(OP_FIND, 32'h7FFF_FFFF, '0);
    send_request(OP_SPARE, 32'h8000_0000, '1);
    send_request(OP_DELETE, 32'h0001_2345, '0);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_DELETE, '1, '0);

    // capacity lowered to the record count, then to zero
    write_capacity(7'd1);
    send_request(OP_INSERT, 32'd5, '1);
    send_request(OP_DELETE, 32'h8000_0000, '0);
    send_request(OP_INSERT, 32'd5, '1);
    send_request(OP_INSERT, 32'd6, '0);
    send_request(OP_FIND, 32'd6, '0);
    write_capacity(7'd0);
    send_request(OP_INSERT, 32'd7, '1);
    send_request(OP_DELETE, 32'd5, '0);
    send_request(OP_INSERT, 32'd8, '0);

    // random phases over capacity settings and idling modes
    for (phase = 0; phase < PHASES; phase++) begin
      write_capacity(phase_caps[phase]);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 54;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct <= 16;
        end
      endcase
      if (phase == 4) hold_requests <= hold_requests + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_drained();
        send_random_request();
      end
    end

    wait_drained();
    repeat (LATENCY_SLACK) @(posedge clk);
    $display("covered find, insert, delete and the spare op code: %0d requests, %0d checked",
             item_count, results_checked);
    $display("capacity written %0d times incl. 0, 1, 64 and 127, with stalls and a long hold",
             cfg_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
